// ----- sv/terminal_line_discipline_macros.svh -----
// Assertion macros shared by the terminal line discipline checkers.
// Needs nothing else; take it in with a plain include.
`ifndef TERMINAL_LINE_DISCIPLINE_MACROS_SVH
`define TERMINAL_LINE_DISCIPLINE_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define TLD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("terminal line discipline check failed");

// Next-cycle implication, disabled while reset is low.
`define TLD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("terminal line discipline check failed");

`endif

// ----- sv/tld_pkg.sv -----
// Shared types, codes and constants of the terminal line discipline.
// Used by the controller, the datapath, the top level and the checker.
`default_nettype none

package tld_pkg;

    localparam int LINE_DEPTH_DEF = 32;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 40;
    localparam int BYTE_W         = 8;
    localparam int KIND_W         = 3;
    localparam int OUT_DATA_W     = 16;

    localparam logic [7:0] NUL_CHAR   = 8'd0;
    localparam logic [7:0] BS_CHAR    = 8'd8;
    localparam logic [7:0] TAB_CHAR   = 8'd9;
    localparam logic [7:0] NL_CHAR    = 8'd10;
    localparam logic [7:0] SPACE_CHAR = 8'd32;
    localparam logic [7:0] CARET_CHAR = 8'd94;
    localparam logic [7:0] CTRL_OFS   = 8'd64;

    localparam logic        CANON_RST        = 1'b1;
    localparam logic        ECHO_RST         = 1'b1;
    localparam logic        SIG_RST          = 1'b1;
    localparam logic [31:0] EDIT_CHARS_RST   = 32'd168039688;
    localparam logic [39:0] SIGNAL_CHARS_RST = 40'd73334922243;

    typedef enum logic [KIND_W-1:0] {
        K_ECHO    = 3'd0,
        K_DELIVER = 3'd1,
        K_SIGNAL  = 3'd2,
        K_EOF     = 3'd3,
        K_FLOW    = 3'd4
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CANON        = 3'd0,
        CFG_ECHO         = 3'd1,
        CFG_SIG          = 3'd2,
        CFG_EDIT_CHARS   = 3'd3,
        CFG_SIGNAL_CHARS = 3'd4
    } t_cfg_idx;

    typedef enum logic [3:0] {
        VS_CH,
        VS_CH_PLUS64,
        VS_CARET,
        VS_NEWLINE,
        VS_BACKSPACE,
        VS_ZERO,
        VS_ONE,
        VS_TWO,
        VS_RDATA
    } t_val_sel;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ECHO0,
        S_ECHO1,
        S_ECHO2,
        S_SIG,
        S_CANON,
        S_KILL,
        S_STORE,
        S_REL0,
        S_REL,
        S_DONE
    } t_state;

    // Commands from controller to datapath. Side effects that go with an
    // emit take place only when the emit is taken.
    typedef struct packed {
        logic     load_ch;
        logic     emit;
        t_kind    kind;
        t_val_sel vsel;
        logic     set_stop;
        logic     clr_stop;
        logic     dec_count;
        logic     clr_count;
        logic     set_ch_zero;
        logic     set_ch_nl;
        logic     store;
        logic     rd_first;
        logic     rd_next;
        logic     flush;
    } t_cmd;

    typedef struct packed {
        logic echo_en;
        logic canon;
        logic sig_en;
        logic skip_sig;
        logic ctrl_echo;
        logic m_intr;
        logic m_stop;
        logic m_start;
        logic m_susp;
        logic m_quit;
        logic m_erase;
        logic m_kill;
        logic m_eof;
        logic m_eol;
        logic count_zero;
        logic count_one;
        logic rel_now;
        logic rd_zero;
        logic rd_nl;
        logic idx_last;
        logic emit_ok;
        logic flush_ok;
    } t_status;

endpackage

`default_nettype wire

// ----- sv/tld_ctrl.sv -----
// Sequencer of the terminal line discipline: walks one received byte
// through echo, signal, edit and release steps. Depends on tld_pkg.
`default_nettype none

module tld_ctrl
    import tld_pkg::*;
(
    input  wire     i_clk,
    input  wire     i_rst_n,
    input  wire     i_s_valid,
    output logic    o_s_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        o_cmd     = '0;
        o_s_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_s_ready = 1'b1;
                if (i_s_valid) begin
                    o_cmd.load_ch = 1'b1;
                    n_state       = S_ECHO0;
                end
            end
            S_ECHO0: begin
                if (i_status.echo_en && !i_status.skip_sig) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.kind = K_ECHO;
                    if (i_status.ctrl_echo) begin
                        o_cmd.vsel = VS_CARET;
                        if (i_status.emit_ok) n_state = S_ECHO1;
                    end else begin
                        o_cmd.vsel = VS_CH;
                        if (i_status.emit_ok) n_state = S_SIG;
                    end
                end else begin
                    n_state = S_SIG;
                end
            end
            S_ECHO1: begin
                o_cmd.emit = 1'b1;
                o_cmd.kind = K_ECHO;
                o_cmd.vsel = VS_CH_PLUS64;
                if (i_status.emit_ok) n_state = S_ECHO2;
            end
            S_ECHO2: begin
                o_cmd.emit = 1'b1;
                o_cmd.kind = K_ECHO;
                o_cmd.vsel = VS_NEWLINE;
                if (i_status.emit_ok) n_state = S_SIG;
            end
            S_SIG: begin
                if (i_status.sig_en && !i_status.skip_sig &&
                    (i_status.m_intr || i_status.m_stop || i_status.m_start ||
                     i_status.m_susp || i_status.m_quit)) begin
                    o_cmd.emit = 1'b1;
                    if (i_status.m_intr) begin
                        o_cmd.kind = K_SIGNAL;
                        o_cmd.vsel = VS_ZERO;
                    end else if (i_status.m_stop) begin
                        o_cmd.kind     = K_FLOW;
                        o_cmd.vsel     = VS_ZERO;
                        o_cmd.set_stop = 1'b1;
                    end else if (i_status.m_start) begin
                        o_cmd.kind     = K_FLOW;
                        o_cmd.vsel     = VS_ZERO;
                        o_cmd.clr_stop = 1'b1;
                    end else if (i_status.m_susp) begin
                        o_cmd.kind = K_SIGNAL;
                        o_cmd.vsel = VS_ONE;
                    end else begin
                        o_cmd.kind = K_SIGNAL;
                        o_cmd.vsel = VS_TWO;
                    end
                    if (i_status.emit_ok) n_state = S_DONE;
                end else if (i_status.canon) begin
                    n_state = S_CANON;
                end else begin
                    o_cmd.emit = 1'b1;
                    o_cmd.kind = K_DELIVER;
                    o_cmd.vsel = VS_CH;
                    if (i_status.emit_ok) n_state = S_DONE;
                end
            end
            S_CANON: begin
                if (i_status.m_erase) begin
                    if (i_status.count_zero) begin
                        n_state = S_DONE;
                    end else begin
                        o_cmd.emit      = 1'b1;
                        o_cmd.kind      = K_ECHO;
                        o_cmd.vsel      = VS_CH;
                        o_cmd.dec_count = 1'b1;
                        if (i_status.emit_ok) n_state = S_DONE;
                    end
                end else if (i_status.m_kill) begin
                    n_state = i_status.count_zero ? S_DONE : S_KILL;
                end else if (i_status.m_eof) begin
                    o_cmd.set_ch_zero = 1'b1;
                    n_state           = S_STORE;
                end else if (i_status.m_eol) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.kind      = K_ECHO;
                    o_cmd.vsel      = VS_NEWLINE;
                    o_cmd.set_ch_nl = 1'b1;
                    if (i_status.emit_ok) n_state = S_STORE;
                end else begin
                    n_state = S_STORE;
                end
            end
            S_KILL: begin
                o_cmd.emit      = 1'b1;
                o_cmd.kind      = K_ECHO;
                o_cmd.vsel      = VS_BACKSPACE;
                o_cmd.dec_count = 1'b1;
                if (i_status.emit_ok && i_status.count_one) n_state = S_DONE;
            end
            S_STORE: begin
                o_cmd.store = 1'b1;
                n_state     = i_status.rel_now ? S_REL0 : S_DONE;
            end
            S_REL0: begin
                o_cmd.rd_first = 1'b1;
                n_state        = S_REL;
            end
            S_REL: begin
                o_cmd.emit = 1'b1;
                if (i_status.rd_zero) begin
                    o_cmd.kind      = K_EOF;
                    o_cmd.vsel      = VS_ZERO;
                    o_cmd.clr_count = 1'b1;
                    if (i_status.emit_ok) n_state = S_DONE;
                end else begin
                    o_cmd.kind = K_DELIVER;
                    o_cmd.vsel = VS_RDATA;
                    if (i_status.rd_nl || i_status.idx_last) begin
                        o_cmd.clr_count = 1'b1;
                        if (i_status.emit_ok) n_state = S_DONE;
                    end else begin
                        o_cmd.rd_next = 1'b1;
                    end
                end
            end
            S_DONE: begin
                o_cmd.flush = 1'b1;
                if (i_status.flush_ok) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

`default_nettype wire

// ----- sv/tld_datapath.sv -----
// Datapath of the terminal line discipline: settings, byte matchers, line
// store, result hold and output registers. Depends on tld_pkg.
`default_nettype none

module tld_datapath
    import tld_pkg::*;
#(
    parameter int LINE_DEPTH = LINE_DEPTH_DEF
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_cfg_valid,
    input  wire  [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire  [CFG_DATA_W-1:0]  i_cfg_data,
    input  wire  [BYTE_W-1:0]      i_s_data,
    input  t_cmd                   i_cmd,
    output t_status                o_status,
    output logic                   o_m_valid,
    input  wire                    i_m_ready,
    output t_kind                  o_m_kind,
    output logic [BYTE_W-1:0]      o_m_value,
    output logic                   o_m_stopped,
    output logic                   o_m_last
);

    localparam int AW = $clog2(LINE_DEPTH);
    localparam int CW = $clog2(LINE_DEPTH + 1);

    logic        r_canon, r_echo, r_sig;
    logic [31:0] r_edit;
    logic [39:0] r_sigc;
    logic        r_stopped;
    logic [CW-1:0] r_count;
    logic [AW-1:0] r_idx;
    logic [BYTE_W-1:0] r_ch;
    logic [BYTE_W-1:0] r_rd;
    logic [BYTE_W-1:0] mem [LINE_DEPTH];

    logic        r_hold_v;
    t_kind       r_hold_kind;
    logic [BYTE_W-1:0] r_hold_val;
    logic        r_hold_stop;

    logic        out_free, emit_ok, adv, emit_fire, flush_fire, out_load, out_last;
    logic        room;
    logic [BYTE_W-1:0] val;
    logic        emit_stop;

    assign out_free   = !o_m_valid || i_m_ready;
    assign emit_ok    = !r_hold_v || out_free;
    assign adv        = !i_cmd.emit || emit_ok;
    assign emit_fire  = i_cmd.emit && emit_ok;
    assign flush_fire = i_cmd.flush && r_hold_v && out_free;
    assign out_load   = (emit_fire && r_hold_v) || flush_fire;
    assign out_last   = flush_fire;
    assign room       = r_count < CW'(LINE_DEPTH);

    // Settings write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_canon <= CANON_RST;
            r_echo  <= ECHO_RST;
            r_sig   <= SIG_RST;
            r_edit  <= EDIT_CHARS_RST;
            r_sigc  <= SIGNAL_CHARS_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_CANON:        r_canon <= i_cfg_data[0];
                CFG_ECHO:         r_echo  <= i_cfg_data[0];
                CFG_SIG:          r_sig   <= i_cfg_data[0];
                CFG_EDIT_CHARS:   r_edit  <= i_cfg_data[31:0];
                CFG_SIGNAL_CHARS: r_sigc  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Line count and stopped flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_stopped <= 1'b0;
        end else begin
            if (adv) begin
                if (i_cmd.clr_count) begin
                    r_count <= '0;
                end else if (i_cmd.dec_count) begin
                    r_count <= r_count - CW'(1);
                end else if (i_cmd.store && room) begin
                    r_count <= r_count + CW'(1);
                end
            end
            if (emit_fire && i_cmd.set_stop) begin
                r_stopped <= 1'b1;
            end else if (emit_fire && i_cmd.clr_stop) begin
                r_stopped <= 1'b0;
            end
        end
    end

    // Working byte and release index
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_ch) begin
            r_ch <= i_s_data;
        end else if (adv && i_cmd.set_ch_zero) begin
            r_ch <= NUL_CHAR;
        end else if (adv && i_cmd.set_ch_nl) begin
            r_ch <= NL_CHAR;
        end
        if (adv && i_cmd.rd_first) begin
            r_idx <= '0;
        end else if (adv && i_cmd.rd_next) begin
            r_idx <= r_idx + AW'(1);
        end
    end

    // Line store
    always_ff @(posedge i_clk) begin
        if (adv && i_cmd.store && room) begin
            mem[r_count[AW-1:0]] <= r_ch;
        end
        if (adv && i_cmd.rd_first) begin
            r_rd <= mem[AW'(0)];
        end else if (adv && i_cmd.rd_next) begin
            r_rd <= mem[r_idx + AW'(1)];
        end
    end

    always_comb begin
        case (i_cmd.vsel)
            VS_CH:        val = r_ch;
            VS_CH_PLUS64: val = r_ch + CTRL_OFS;
            VS_CARET:     val = CARET_CHAR;
            VS_NEWLINE:   val = NL_CHAR;
            VS_BACKSPACE: val = BS_CHAR;
            VS_ZERO:      val = 8'd0;
            VS_ONE:       val = 8'd1;
            VS_TWO:       val = 8'd2;
            VS_RDATA:     val = r_rd;
            default:      val = 8'd0;
        endcase
    end

    assign emit_stop = i_cmd.set_stop ? 1'b1 : (i_cmd.clr_stop ? 1'b0 : r_stopped);

    // Hold one result back so the last of a run can be marked
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_v <= 1'b0;
        end else if (emit_fire) begin
            r_hold_v <= 1'b1;
        end else if (flush_fire) begin
            r_hold_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_fire) begin
            r_hold_kind <= i_cmd.kind;
            r_hold_val  <= val;
            r_hold_stop <= emit_stop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_m_valid <= 1'b0;
        end else if (out_load) begin
            o_m_valid <= 1'b1;
        end else if (i_m_ready) begin
            o_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            o_m_kind    <= r_hold_kind;
            o_m_value   <= r_hold_val;
            o_m_stopped <= r_hold_stop;
            o_m_last    <= out_last;
        end
    end

    always_comb begin
        o_status            = '0;
        o_status.echo_en    = r_echo;
        o_status.canon      = r_canon;
        o_status.sig_en     = r_sig;
        o_status.m_erase    = r_ch == r_edit[7:0];
        o_status.m_kill     = r_ch == r_edit[15:8];
        o_status.m_eof      = r_ch == r_edit[23:16];
        o_status.m_eol      = r_ch == r_edit[31:24];
        o_status.skip_sig   = r_echo && r_canon &&
                              (o_status.m_erase || o_status.m_kill ||
                               o_status.m_eof || o_status.m_eol);
        o_status.ctrl_echo  = (r_ch < SPACE_CHAR) && (r_ch != NL_CHAR) && (r_ch != TAB_CHAR);
        o_status.m_intr     = r_ch == r_sigc[7:0];
        o_status.m_quit     = r_ch == r_sigc[15:8];
        o_status.m_susp     = r_ch == r_sigc[23:16];
        o_status.m_stop     = r_ch == r_sigc[31:24];
        o_status.m_start    = r_ch == r_sigc[39:32];
        o_status.count_zero = r_count == '0;
        o_status.count_one  = r_count == CW'(1);
        o_status.rel_now    = (r_ch == NUL_CHAR) || (r_ch == NL_CHAR) ||
                              (r_count >= CW'(LINE_DEPTH - 1));
        o_status.rd_zero    = r_rd == NUL_CHAR;
        o_status.rd_nl      = r_rd == NL_CHAR;
        o_status.idx_last   = (CW'(r_idx) + CW'(1)) >= r_count;
        o_status.emit_ok    = emit_ok;
        o_status.flush_ok   = !r_hold_v || out_free;
    end

endmodule

`default_nettype wire

// ----- sv/terminal_line_discipline.sv -----
// Terminal line discipline top level: sequencer plus datapath.
// Depends on tld_pkg, tld_ctrl and tld_datapath.
//
// Usage: received bytes come in on the slave stream (s_tdata = the byte).
// Each byte yields a run of zero or more results on the master stream; the
// last result of a run carries tlast. tuser holds the result kind (echo,
// delivery, signal, end of file, flow change); tdata holds the value byte
// and, above it, the output-stopped flag. Settings are written through the
// cfg channel (index 0 canonical mode, 1 echo, 2 signals, 3 edit bytes,
// 4 signal bytes), which is always ready and should be used only when idle.
// A byte is taken only while the sequencer is idle, so bytes are handled one
// at a time. A kill echoes one backspace per stored byte, and a line release
// delivers each stored byte in turn (line store read port, one entry per
// cycle while the receiver does not stall).
// Reset (synchronous, active low) restores the default settings, empties
// the line and clears the stopped flag. When the receiver stalls, the
// current result holds in the output register and the sequencer waits.
`default_nettype none

module terminal_line_discipline
    import tld_pkg::*;
#(
    parameter int LINE_DEPTH = LINE_DEPTH_DEF
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    // slave stream
    input  wire                    i_s_tvalid,
    output logic                   o_s_tready,
    input  wire  [BYTE_W-1:0]      i_s_tdata,   // [7:0] received_byte
    // master stream
    output logic                   o_m_tvalid,
    input  wire                    i_m_tready,
    output logic [OUT_DATA_W-1:0]  o_m_tdata,   // [7:0] value, [8] stopped, rest zero
    output logic [KIND_W-1:0]      o_m_tuser,   // [2:0] kind
    output logic                   o_m_tlast,
    // settings write channel
    input  wire                    i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire  [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire  [CFG_DATA_W-1:0]  i_cfg_data
);

    t_cmd              cmd;
    t_status           status;
    t_kind             m_kind;
    logic [BYTE_W-1:0] m_value;
    logic              m_stopped;

    // Settings are plain registers; take a write every cycle.
    assign o_cfg_ready = 1'b1;

    tld_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_tvalid),
        .o_s_ready (o_s_tready),
        .i_status  (status),
        .o_cmd     (cmd)
    );

    tld_datapath #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_data    (i_s_tdata),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_m_valid   (o_m_tvalid),
        .i_m_ready   (i_m_tready),
        .o_m_kind    (m_kind),
        .o_m_value   (m_value),
        .o_m_stopped (m_stopped),
        .o_m_last    (o_m_tlast)
    );

    // Pack value and stopped flag; pad to whole bytes.
    assign o_m_tdata = {{(OUT_DATA_W - BYTE_W - 1){1'b0}}, m_stopped, m_value};
    assign o_m_tuser = m_kind;

endmodule

`default_nettype wire

// ----- sv/tld_checker.sv -----
// Port-level checks of the terminal line discipline, bound to the top level.
// Depends on tld_pkg and terminal_line_discipline_macros.svh.
`default_nettype none
`include "terminal_line_discipline_macros.svh"

module tld_checker
    import tld_pkg::*;
(
    input wire                   i_clk,
    input wire                   i_rst_n,
    input wire                   i_s_tvalid,
    input wire                   o_s_tready,
    input wire [BYTE_W-1:0]      i_s_tdata,
    input wire                   o_m_tvalid,
    input wire                   i_m_tready,
    input wire [OUT_DATA_W-1:0]  o_m_tdata,
    input wire [KIND_W-1:0]      o_m_tuser,
    input wire                   o_m_tlast,
    input wire                   i_cfg_valid,
    input wire                   o_cfg_ready,
    input wire [CFG_IDX_W-1:0]   i_cfg_index,
    input wire [CFG_DATA_W-1:0]  i_cfg_data
);

    // A stalled result holds still.
    `TLD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser) && $stable(o_m_tlast))

    // One byte at a time: ready drops right after a request is taken.
    `TLD_ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n, i_s_tvalid && o_s_tready, !o_s_tready)

    // No new byte while a run is still going out.
    `TLD_ASSERT_NOW(a_run_blocks_input, i_clk, i_rst_n, o_m_tvalid && !o_m_tlast, !o_s_tready)

    // Signal, end of file and flow results always end their run.
    `TLD_ASSERT_NOW(a_terminal_kinds_last, i_clk, i_rst_n, o_m_tvalid && (o_m_tuser == K_SIGNAL || o_m_tuser == K_EOF || o_m_tuser == K_FLOW), o_m_tlast)

endmodule

bind terminal_line_discipline tld_checker u_tld_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_s_tvalid  (i_s_tvalid),
    .o_s_tready  (o_s_tready),
    .i_s_tdata   (i_s_tdata),
    .o_m_tvalid  (o_m_tvalid),
    .i_m_tready  (i_m_tready),
    .o_m_tdata   (o_m_tdata),
    .o_m_tuser   (o_m_tuser),
    .o_m_tlast   (o_m_tlast),
    .i_cfg_valid (i_cfg_valid),
    .o_cfg_ready (o_cfg_ready),
    .i_cfg_index (i_cfg_index),
    .i_cfg_data  (i_cfg_data)
);

`default_nettype wire
